[src/jsu_pkg.sv]
// Package for the JSON string unescape decoder: payload types, codes and helpers.
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;

  localparam logic [2:0] ST_BYTE   = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_UNTERM = 3'd2;
  localparam logic [2:0] ST_BADESC = 3'd3;
  localparam logic [2:0] ST_SHORT  = 3'd4;
  localparam logic [2:0] ST_BADHEX = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_ends;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // One queued command: 1 to 3 results, all bytes precomputed.
  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } esc_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r.value = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r.value = c[3:0] + 4'd9;
    else r.valid = 1'b0;
    return r;
  endfunction

  function automatic esc_t escape_byte(input logic [7:0] c);
    esc_t r;
    r.valid = 1'b1;
    unique case (c)
      8'h22:   r.value = 8'h22;
      8'h5C:   r.value = 8'h5C;
      8'h2F:   r.value = 8'h2F;
      8'h6E:   r.value = 8'h0A;
      8'h72:   r.value = 8'h0D;
      8'h74:   r.value = 8'h09;
      8'h62:   r.value = 8'h08;
      8'h66:   r.value = 8'h0C;
      default: begin
        r.valid = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t status_cmd(input logic [2:0] st);
    cmd_t r;
    r.cnt = 2'd1;
    r.status = st;
    r.b0 = 8'h00;
    r.b1 = 8'h00;
    r.b2 = 8'h00;
    return r;
  endfunction

  function automatic cmd_t byte_cmd(input logic [7:0] b);
    cmd_t r;
    r = status_cmd(ST_BYTE);
    r.b0 = b;
    return r;
  endfunction

  function automatic cmd_t utf8_cmd(input logic [15:0] cp);
    cmd_t r;
    r = status_cmd(ST_BYTE);
    if (cp < 16'h0080) begin
      r.b0 = cp[7:0];
    end else if (cp < 16'h0800) begin
      r.cnt = 2'd2;
      r.b0 = 8'hC0 | {3'b000, cp[10:6]};
      r.b1 = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.cnt = 2'd3;
      r.b0 = 8'hE0 | {4'h0, cp[15:12]};
      r.b1 = 8'h80 | {2'b00, cp[11:6]};
      r.b2 = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[src/jsu_front.sv]
// Front end: accepts text bytes, tracks escape state and builds result commands.
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_ready,
  output logic     push,
  output cmd_t     cmd
);

  logic [1:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;
  logic        take;
  hex_t        hv;
  esc_t        ev;
  logic [15:0] cp_shift;

  assign in_ready = q_ready;
  assign take = in_valid && in_ready;
  assign hv = hex_value(in_data.in_byte);
  assign ev = escape_byte(in_data.in_byte);
  assign cp_shift = {code_point[11:0], hv.value};

  always_comb begin
    mode_next = mode;
    hex_count_next = hex_count;
    code_point_next = code_point;
    push = 1'b0;
    cmd = status_cmd(ST_UNTERM);
    priority if (in_data.text_ends) begin
      push = 1'b1;
      if (mode == MODE_ESC) cmd = status_cmd(ST_BADESC);
      else if (mode == MODE_HEX) cmd = status_cmd(ST_SHORT);
      mode_next = MODE_PLAIN;
      hex_count_next = 2'd0;
      code_point_next = 16'd0;
    end else if (mode == MODE_ESC) begin
      if (in_data.in_byte == CH_U) begin
        mode_next = MODE_HEX;
        hex_count_next = 2'd0;
        code_point_next = 16'd0;
      end else if (ev.valid) begin
        push = 1'b1;
        cmd = byte_cmd(ev.value);
        mode_next = MODE_PLAIN;
      end else begin
        push = 1'b1;
        cmd = status_cmd(ST_BADESC);
        mode_next = MODE_PLAIN;
        hex_count_next = 2'd0;
        code_point_next = 16'd0;
      end
    end else if (mode == MODE_HEX) begin
      if (!hv.valid) begin
        push = 1'b1;
        cmd = status_cmd(ST_BADHEX);
        mode_next = MODE_PLAIN;
        hex_count_next = 2'd0;
        code_point_next = 16'd0;
      end else if (hex_count == 2'd3) begin
        push = 1'b1;
        cmd = utf8_cmd(cp_shift);
        mode_next = MODE_PLAIN;
        hex_count_next = 2'd0;
        code_point_next = 16'd0;
      end else begin
        hex_count_next = hex_count + 2'd1;
        code_point_next = cp_shift;
      end
    end else begin
      // plain body, also the unused mode code
      if (in_data.in_byte == CH_QUOTE) begin
        push = 1'b1;
        cmd = status_cmd(ST_CLOSED);
        mode_next = MODE_PLAIN;
        hex_count_next = 2'd0;
        code_point_next = 16'd0;
      end else if (in_data.in_byte == CH_BSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        push = 1'b1;
        cmd = byte_cmd(in_data.in_byte);
        mode_next = MODE_PLAIN;
      end
    end
    if (!take) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      hex_count <= 2'd0;
      code_point <= 16'd0;
    end else if (take) begin
      mode <= mode_next;
      hex_count <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

[src/jsu_queue.sv]
// Short command queue between the front end and the output sequencer.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output cmd_t rd_cmd
);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign q_ready = (count != QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/jsu_back.sv]
// Output sequencer: walks the bytes of the head command, one result per transaction.
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] idx;
  logic       is_last;
  logic       fire;

  assign out_valid = q_valid;
  assign fire = out_valid && out_ready;
  assign is_last = (idx == q_cmd.cnt - 2'd1);
  assign pop = fire && is_last;

  always_comb begin
    unique case (idx)
      2'd0:    out_data.out_byte = q_cmd.b0;
      2'd1:    out_data.out_byte = q_cmd.b1;
      default: out_data.out_byte = q_cmd.b2;
    endcase
    out_data.status = q_cmd.status;
    out_data.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

[src/json_string_unescape_decoder.sv]
// Top level: JSON string body decoder with UTF-8 output of unicode escapes.
// A result is first written into the command queue and is offered at the output from there.
// Throughput: one input byte per cycle; output runs at one result per cycle while
// out_ready is high, so a unicode escape's 2- or 3-byte burst drains from the 4-entry
// command queue. Input stalls only while the command queue is full.
// Reset (rst, synchronous) returns to plain body mode and empties the queue.
module json_string_unescape_decoder import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic push;
  logic pop;
  logic q_ready;
  logic q_valid;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .push     (push),
    .cmd      (wr_cmd)
  );

  jsu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_cmd  (wr_cmd),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_cmd  (rd_cmd)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (rd_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/jsu_checker.sv]
// Port-level checker for the JSON string decoder, bound to the top level.
module jsu_checker import jsu_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_BADHEX)
    else $error("status code out of range");

  // a status transaction always stands alone
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_BYTE |-> out_data.last &&
    out_data.out_byte == 8'h00)
    else $error("status result not single or carries a byte");

  // a result needs an earlier input transaction
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a prior input");

endmodule

bind json_string_unescape_decoder jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
